// ===== rtl/pdc_pkg.sv =====
package pdc_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int PTR_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;
    localparam int ID_W        = 8;

    // Time keeping
    localparam int PERIOD_W                   = 20;
    localparam int ACC_W                      = 21;
    localparam logic [ACC_W-1:0] ACC_MAX      = {ACC_W{1'b1}};
    localparam logic [PERIOD_W-1:0] STEP_PERIOD_RESET = PERIOD_W'(750 * 1000);

    // Action codes
    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_PUSH    = 3'd1,
        ACT_DEL_MSG = 3'd2,
        ACT_DEL_PKT = 3'd3,
        ACT_CLEAR   = 3'd4,
        ACT_PAUSE   = 3'd5,
        ACT_RESUME  = 3'd6
    } t_action;

    // One queued packet
    typedef struct packed {
        logic [ID_W-1:0] handle;
        logic [ID_W-1:0] msg;
        logic [ID_W-1:0] pkt;
    } t_entry;

    // Displayed selection
    typedef struct packed {
        logic   valid;
        t_entry ent;
    } t_sel;

    // Table write request
    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] addr;
        t_entry           data;
    } t_wr_req;

endpackage

// ===== rtl/packet_display_carousel_top.sv =====
// Packet display carousel.
// Input channel (i_in_valid / o_in_stall) carries one action per beat: tick,
// push, delete message, delete packet, clear, pause or resume. Output channel
// (o_out_valid / i_out_stall) returns exactly one result beat per input beat:
// the currently shown entry plus changed, clear_display and push_dropped.
// The user writes step_period_us through i_cfg_we / i_cfg_data only while
// idle; the block itself does not enforce this. Push, clear, pause, resume
// and paused ticks go straight to the result. An unpaused tick adds the
// elapsed time, then subtracts/compares it against the period; a tick that
// advances on a non-empty table then updates the cursor and reads the table.
// Deletes walk the table once through its single read port. One beat is in
// flight at a time; o_in_stall is high from acceptance until the result is
// registered.
// The result sits in an output register, so a new beat is taken while the
// previous result waits on i_out_stall; a finished item holds there until the
// register frees up. Reset (i_rst_n low, synchronous) empties the table,
// clears cursors, time and pause, invalidates the selection and restores the
// period to 750000 us.
module packet_display_carousel_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config
    input  logic                            i_cfg_we,
    input  logic [pdc_pkg::PERIOD_W-1:0]    i_cfg_data,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_action,
    input  logic [pdc_pkg::PERIOD_W-1:0]    i_elapsed_us,
    input  logic [pdc_pkg::ID_W-1:0]        i_msg_id,
    input  logic [pdc_pkg::ID_W-1:0]        i_pkt_id,
    input  logic [pdc_pkg::ID_W-1:0]        i_image_handle,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_shown_valid,
    output logic [pdc_pkg::ID_W-1:0]        o_shown_handle,
    output logic [pdc_pkg::ID_W-1:0]        o_shown_msg,
    output logic [pdc_pkg::ID_W-1:0]        o_shown_pkt,
    output logic                            o_changed,
    output logic                            o_clear_display,
    output logic                            o_push_dropped
);
    import pdc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_CMP,
        S_ADV,
        S_SEL,
        S_DEL,
        S_DONE
    } t_state;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    // state
    t_state                r_state, n_state;
    logic [PERIOD_W-1:0]   r_period, n_period;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [PTR_W-1:0]      r_slow, n_slow;
    logic [PTR_W-1:0]      r_fast, n_fast;
    logic [1:0]            r_phase, n_phase;
    logic [ACC_W-1:0]      r_acc, n_acc;
    logic                  r_paused, n_paused;
    t_sel                  r_shown, n_shown;
    // per-item working registers
    logic [PERIOD_W-1:0]   r_elapsed, n_elapsed;
    logic [ID_W-1:0]       r_msg, n_msg;
    logic [ID_W-1:0]       r_pkt, n_pkt;
    logic                  r_match_pkt, n_match_pkt;
    logic [CNT_W-1:0]      r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]      r_wr_idx, n_wr_idx;
    logic                  r_pend, n_pend;
    logic                  r_chg, n_chg;
    logic                  r_clr, n_clr;
    logic                  r_drop, n_drop;
    // output register
    logic                  r_out_valid, n_out_valid;
    t_sel                  r_out_sel, n_out_sel;
    logic                  r_out_chg, n_out_chg;
    logic                  r_out_clr, n_out_clr;
    logic                  r_out_drop, n_out_drop;

    // table port
    t_wr_req               wr;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;
    t_entry                rd_data;

    // shared add/subtract unit
    logic [PERIOD_W-1:0]   alu_b;
    logic                  alu_sub;
    logic [ACC_W:0]        alu_sum;

    // cursor helpers
    logic [PTR_W-1:0]      slow_fix;
    logic [PTR_W-1:0]      fast_fix;
    logic [PTR_W-1:0]      cur;
    logic [1:0]            ph;
    logic                  acc_gt;
    logic                  hit;
    logic                  rd_more;
    t_sel                  sel;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p,
                                                   input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] inc;
        inc = {1'b0, p} + CNT_W'(1);
        return (inc >= cnt) ? '0 : inc[PTR_W-1:0];
    endfunction

    pdc_table u_table (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign alu_sum = alu_sub ? ({1'b0, r_acc} - (ACC_W+1)'(alu_b))
                             : ({1'b0, r_acc} + (ACC_W+1)'(alu_b));
    assign acc_gt  = !alu_sum[ACC_W] && (alu_sum != '0);

    assign slow_fix = ({1'b0, r_slow} >= r_count) ? '0 : r_slow;
    assign fast_fix = ({1'b0, r_fast} >= r_count) ? '0 : r_fast;
    assign ph       = r_phase + 2'd1;
    assign rd_more  = (r_rd_idx < r_count);
    assign hit      = (rd_data.msg == r_msg) && (!r_match_pkt || (rd_data.pkt == r_pkt));
    assign sel      = '{valid: 1'b1, ent: rd_data};

    // next-state logic
    always_comb begin
        n_state     = r_state;
        n_period    = r_period;
        n_count     = r_count;
        n_slow      = r_slow;
        n_fast      = r_fast;
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_paused    = r_paused;
        n_shown     = r_shown;
        n_elapsed   = r_elapsed;
        n_msg       = r_msg;
        n_pkt       = r_pkt;
        n_match_pkt = r_match_pkt;
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_pend      = r_pend;
        n_chg       = r_chg;
        n_clr       = r_clr;
        n_drop      = r_drop;
        n_out_valid = r_out_valid;
        n_out_sel   = r_out_sel;
        n_out_chg   = r_out_chg;
        n_out_clr   = r_out_clr;
        n_out_drop  = r_out_drop;
        wr          = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        alu_b       = r_period;
        alu_sub     = 1'b1;
        cur         = slow_fix;

        if (i_cfg_we) begin
            n_period = i_cfg_data;
        end

        // result beat taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_chg       = 1'b0;
                    n_clr       = 1'b0;
                    n_drop      = 1'b0;
                    n_elapsed   = i_elapsed_us;
                    n_msg       = i_msg_id;
                    n_pkt       = i_pkt_id;
                    n_match_pkt = 1'b0;
                    n_state     = S_DONE;
                    case (t_action'(i_action))
                        ACT_TICK: begin
                            if (!r_paused) begin
                                n_state = S_ACC;
                            end
                        end
                        ACT_PUSH: begin
                            if (r_count >= FULL_CNT) begin
                                n_drop = 1'b1;
                            end else begin
                                wr.we   = 1'b1;
                                wr.addr = r_count[PTR_W-1:0];
                                wr.data = '{handle: i_image_handle, msg: i_msg_id,
                                            pkt: i_pkt_id};
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        ACT_DEL_MSG, ACT_DEL_PKT: begin
                            n_match_pkt = (t_action'(i_action) == ACT_DEL_PKT);
                            n_rd_idx    = '0;
                            n_wr_idx    = '0;
                            n_pend      = 1'b0;
                            n_state     = S_DEL;
                        end
                        ACT_CLEAR: begin
                            n_count = '0;
                            n_slow  = '0;
                            n_fast  = '0;
                            n_phase = '0;
                        end
                        ACT_PAUSE: begin
                            if (!r_paused) begin
                                n_paused = 1'b1;
                                n_clr    = 1'b1;
                            end
                        end
                        ACT_RESUME: begin
                            n_paused = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // accumulate, saturating
            S_ACC: begin
                alu_b   = r_elapsed;
                alu_sub = 1'b0;
                n_acc   = alu_sum[ACC_W] ? ACC_MAX : alu_sum[ACC_W-1:0];
                n_state = S_CMP;
            end

            // period passed: take one period off
            S_CMP: begin
                n_state = S_DONE;
                if (acc_gt) begin
                    n_acc = alu_sum[ACC_W-1:0];
                    if (r_count == '0) begin
                        if (r_shown.valid) begin
                            n_chg = 1'b1;
                            n_clr = 1'b1;
                        end
                        n_shown = '0;
                    end else begin
                        n_state = S_ADV;
                    end
                end
            end

            // four-phase cursor step, then read the chosen entry
            S_ADV: begin
                n_slow  = slow_fix;
                n_fast  = fast_fix;
                n_phase = ph;
                case (ph)
                    2'd0: begin
                        n_slow = next_pos(slow_fix, r_count);
                        cur    = n_slow;
                    end
                    2'd1: begin
                        cur = slow_fix;
                    end
                    default: begin
                        n_fast = next_pos(fast_fix, r_count);
                        cur    = n_fast;
                    end
                endcase
                rd_en   = 1'b1;
                rd_addr = cur;
                n_state = S_SEL;
            end

            S_SEL: begin
                if (sel != r_shown) begin
                    n_shown = sel;
                    n_chg   = 1'b1;
                end
                n_state = S_DONE;
            end

            // compaction walk: read one ahead, write back survivors
            S_DEL: begin
                if (rd_more) begin
                    rd_en    = 1'b1;
                    rd_addr  = r_rd_idx[PTR_W-1:0];
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                    n_pend   = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend && !hit) begin
                    wr.we    = 1'b1;
                    wr.addr  = r_wr_idx[PTR_W-1:0];
                    wr.data  = rd_data;
                    n_wr_idx = r_wr_idx + CNT_W'(1);
                end
                if (!rd_more && !r_pend) begin
                    n_count = r_wr_idx;
                    n_slow  = '0;
                    n_fast  = '0;
                    n_phase = '0;
                    n_state = S_DONE;
                end
            end

            // hand the result to the output register
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_sel   = r_shown;
                    n_out_chg   = r_chg;
                    n_out_clr   = r_clr;
                    n_out_drop  = r_drop;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        r_elapsed   <= n_elapsed;
        r_msg       <= n_msg;
        r_pkt       <= n_pkt;
        r_match_pkt <= n_match_pkt;
        r_rd_idx    <= n_rd_idx;
        r_wr_idx    <= n_wr_idx;
        r_chg       <= n_chg;
        r_clr       <= n_clr;
        r_drop      <= n_drop;
        r_out_sel   <= n_out_sel;
        r_out_chg   <= n_out_chg;
        r_out_clr   <= n_out_clr;
        r_out_drop  <= n_out_drop;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= STEP_PERIOD_RESET;
            r_count     <= '0;
            r_slow      <= '0;
            r_fast      <= '0;
            r_phase     <= '0;
            r_acc       <= '0;
            r_paused    <= 1'b0;
            r_shown     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_period    <= n_period;
            r_count     <= n_count;
            r_slow      <= n_slow;
            r_fast      <= n_fast;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_paused    <= n_paused;
            r_shown     <= n_shown;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_shown_valid   = r_out_sel.valid;
    assign o_shown_handle  = r_out_sel.ent.handle;
    assign o_shown_msg     = r_out_sel.ent.msg;
    assign o_shown_pkt     = r_out_sel.ent.pkt;
    assign o_changed       = r_out_chg;
    assign o_clear_display = r_out_clr;
    assign o_push_dropped  = r_out_drop;

endmodule

// ===== rtl/pdc_table.sv =====
module pdc_table (
    input  logic                          i_clk,
    input  pdc_pkg::t_wr_req              i_wr,
    input  logic                          i_re,
    input  logic [pdc_pkg::PTR_W-1:0]     i_raddr,
    output pdc_pkg::t_entry               o_rdata
);
    import pdc_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
